### rtl/core/plavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plavg_pkg - shared definitions for the periodic load average block
// Widths, register map, reset values and the decay arithmetic used by the
// update of each average.
// ----------------------------------------------------------------------------
package plavg_pkg;

    localparam int FRACTION_BITS = 11;
    localparam int FACTOR_W      = FRACTION_BITS + 1;
    localparam int COUNT_W       = 16;
    localparam int AVG_W         = 32;
    localparam int TIME_W        = 32;
    localparam int INTERVAL_W    = 8;
    localparam int LANES         = 3;

    // stream payload widths
    localparam int IN_DATA_W     = 48;                 // 8 + 8 + 32 bits
    localparam int OUT_DATA_W    = 2 * LANES * AVG_W;  // six averages

    // configuration port
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [FACTOR_W-1:0] UNIT_SCALE = FACTOR_W'(1) << FRACTION_BITS;

    typedef enum logic [1:0] {
        REG_INTERVAL     = 2'd0,
        REG_DECAY_SHORT  = 2'd1,
        REG_DECAY_MEDIUM = 2'd2,
        REG_DECAY_LONG   = 2'd3
    } reg_index_t;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET     = 8'd5;
    localparam logic [11:0]           DECAY_SHORT_RESET  = 12'd1884;
    localparam logic [11:0]           DECAY_MEDIUM_RESET = 12'd2014;
    localparam logic [11:0]           DECAY_LONG_RESET   = 12'd2036;

    // avg' = ((c*avg) >> F) + n*(2^F - c), taken mod 2^32; the second term of
    // the full form is a whole multiple of 2^F so it survives the shift intact
    function automatic logic [AVG_W-1:0] decay_avg(
        input logic [AVG_W-1:0]   avg,
        input logic [COUNT_W-1:0] count,
        input logic [11:0]        factor
    );
        logic [FACTOR_W-1:0]         c;
        logic [FACTOR_W+AVG_W-1:0]   prod;
        logic [FACTOR_W+COUNT_W-1:0] fresh;
        logic [AVG_W-1:0]            kept;
        if (factor > 12'(UNIT_SCALE))
        begin
            c = UNIT_SCALE;
        end
        else
        begin
            c = factor[FACTOR_W-1:0];
        end
        prod  = (FACTOR_W+AVG_W)'(c) * (FACTOR_W+AVG_W)'(avg);
        fresh = (FACTOR_W+COUNT_W)'(count) * (FACTOR_W+COUNT_W)'(UNIT_SCALE - c);
        kept  = prod[FRACTION_BITS +: AVG_W];
        return kept + AVG_W'(fresh);
    endfunction

endpackage

### rtl/core/periodic_load_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_load_average - periodic exponential load averages of two counts
// Keeps a reader count and a startup count and, each time the item time
// reaches the deadline, decays three averages per count by one step.
// ----------------------------------------------------------------------------
// Flow: a request accepted into the input register moves on once the result
// slot is free or being taken, and its result is registered for the master side.
// Throughput: one request per cycle while the master side takes each result; the input register feeds a single pass
// of six parallel multiply-adds straight into the state and result registers.
// Reset: rst_n clears counts, deadline and averages and loads the register
// defaults (interval 5, decay factors 1884, 2014, 2036); no clearing pass.
module periodic_load_average (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // reader_delta [7:0], startup_delta [15:8], now_seconds [47:16]
    input  logic [plavg_pkg::IN_DATA_W-1:0]     s_tdata,
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // reader_avg_short/medium/long [95:0], startup_avg_short/medium/long [191:96]
    output logic [plavg_pkg::OUT_DATA_W-1:0]    m_tdata,
    // updated [0]
    output logic                                m_tuser,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [plavg_pkg::ADDR_W-1:0]        paddr,
    input  logic [plavg_pkg::DATA_W-1:0]        pwdata,
    output logic [plavg_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);
    import plavg_pkg::*;

    // configuration registers
    logic [INTERVAL_W-1:0] interval_reg;
    logic [11:0]           decay_reg [LANES];
    logic                  cfg_write;
    reg_index_t            cfg_index;

    // input register
    logic                  in_valid_reg;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  advance;

    // block state
    logic [COUNT_W-1:0]    reader_total_reg;
    logic [COUNT_W-1:0]    startup_total_reg;
    logic [TIME_W-1:0]     deadline_reg;
    logic                  deadline_set_reg;
    logic [AVG_W-1:0]      reader_avg_reg  [LANES];
    logic [AVG_W-1:0]      startup_avg_reg [LANES];

    // next values
    logic [COUNT_W-1:0]    reader_total_next;
    logic [COUNT_W-1:0]    startup_total_next;
    logic [TIME_W-1:0]     deadline_next;
    logic [AVG_W-1:0]      reader_avg_next  [LANES];
    logic [AVG_W-1:0]      startup_avg_next [LANES];
    logic                  fire;

    // result register
    logic                  out_valid_reg;
    logic                  out_updated_reg;

    // unpacked request fields
    logic signed [7:0]     reader_delta;
    logic [7:0]            startup_delta;
    logic [TIME_W-1:0]     now_seconds;

    // working values
    logic signed [COUNT_W+1:0] reader_sum;
    logic [COUNT_W:0]          startup_sum;
    logic [COUNT_W-1:0]        reader_level;
    logic [COUNT_W-1:0]        startup_level;
    logic [TIME_W-1:0]         deadline_eff;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            decay_reg[0] <= DECAY_SHORT_RESET;
            decay_reg[1] <= DECAY_MEDIUM_RESET;
            decay_reg[2] <= DECAY_LONG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INTERVAL:     interval_reg <= pwdata[INTERVAL_W-1:0];
                REG_DECAY_SHORT:  decay_reg[0] <= pwdata[11:0];
                REG_DECAY_MEDIUM: decay_reg[1] <= pwdata[11:0];
                REG_DECAY_LONG:   decay_reg[2] <= pwdata[11:0];
                default:          interval_reg <= interval_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_INTERVAL:     prdata = DATA_W'(interval_reg);
            REG_DECAY_SHORT:  prdata = DATA_W'(decay_reg[0]);
            REG_DECAY_MEDIUM: prdata = DATA_W'(decay_reg[1]);
            REG_DECAY_LONG:   prdata = DATA_W'(decay_reg[2]);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- handshake
    // move the held request on whenever the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------ update pass
    assign reader_delta  = in_data_reg[7:0];
    assign startup_delta = in_data_reg[15:8];
    assign now_seconds   = in_data_reg[47:16];

    always_comb
    begin
        // counts change first; the reader count saturates at both ends, the startup count at the top
        reader_sum = $signed({2'b00, reader_total_reg})
                   + $signed({{(COUNT_W-6){reader_delta[7]}}, reader_delta});
        if (reader_sum[COUNT_W+1])
        begin
            reader_level = '0;
        end
        else if (reader_sum[COUNT_W])
        begin
            reader_level = '1;
        end
        else
        begin
            reader_level = reader_sum[COUNT_W-1:0];
        end

        startup_sum = {1'b0, startup_total_reg} + (COUNT_W+1)'(startup_delta);
        if (startup_sum[COUNT_W])
        begin
            startup_level = '1;
        end
        else
        begin
            startup_level = startup_sum[COUNT_W-1:0];
        end

        // first request arms the deadline, then the same request is tested
        if (deadline_set_reg)
        begin
            deadline_eff = deadline_reg;
        end
        else
        begin
            deadline_eff = now_seconds + TIME_W'(interval_reg);
        end

        fire = (now_seconds >= deadline_eff);

        reader_total_next = reader_level;
        if (fire)
        begin
            deadline_next      = deadline_eff + TIME_W'(interval_reg);
            startup_total_next = '0;
        end
        else
        begin
            deadline_next      = deadline_eff;
            startup_total_next = startup_level;
        end

        for (int k = 0; k < LANES; k++)
        begin
            if (fire)
            begin
                reader_avg_next[k]  = decay_avg(reader_avg_reg[k], reader_level,
                                                decay_reg[k]);
                startup_avg_next[k] = decay_avg(startup_avg_reg[k], startup_level,
                                                decay_reg[k]);
            end
            else
            begin
                reader_avg_next[k]  = reader_avg_reg[k];
                startup_avg_next[k] = startup_avg_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reader_total_reg  <= '0;
            startup_total_reg <= '0;
            deadline_reg      <= '0;
            deadline_set_reg  <= 1'b0;
            for (int k = 0; k < LANES; k++)
            begin
                reader_avg_reg[k]  <= '0;
                startup_avg_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            reader_total_reg  <= reader_total_next;
            startup_total_reg <= startup_total_next;
            deadline_reg      <= deadline_next;
            deadline_set_reg  <= 1'b1;
            for (int k = 0; k < LANES; k++)
            begin
                reader_avg_reg[k]  <= reader_avg_next[k];
                startup_avg_reg[k] <= startup_avg_next[k];
            end
        end
    end

    // ---------------------------------------------------------------- result
    // the averages change only when a request advances, which also loads
    // the result slot, so the state registers serve as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_updated_reg <= fire;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_updated_reg;
    assign m_tdata  = {startup_avg_reg[2], startup_avg_reg[1], startup_avg_reg[0],
                       reader_avg_reg[2],  reader_avg_reg[1],  reader_avg_reg[0]};

endmodule
